/* rtl/rtes_pkg.sv */
package rtes_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int MAX_RESULTS     = 64;
  localparam int PAGE_SHIFT      = 12;
  localparam int CODE_MAX        = 10;
  localparam int PHYS_W          = 36;
  localparam int VIRT_W          = 32;
  localparam int SIZE_W          = 32;
  localparam int IDX_W           = 7;
  localparam int CODE_W          = 4;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 7;
  localparam int STEP_W          = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COHERENT_MODE = 2'd1;

  localparam logic [IDX_W-1:0] ENTRY_LIMIT_RST = 7'd16;

  localparam logic [1:0] ST_ENTRY    = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_MISALIGN = 2'd2;
  localparam logic [1:0] ST_END      = 2'd3;

  // microprogram addresses
  localparam logic [STEP_W-1:0] S_WAIT     = 4'd0;
  localparam logic [STEP_W-1:0] S_ENDCHK   = 4'd1;
  localparam logic [STEP_W-1:0] S_VALCHK   = 4'd2;
  localparam logic [STEP_W-1:0] S_FULLCHK  = 4'd3;
  localparam logic [STEP_W-1:0] S_CODECHK  = 4'd4;
  localparam logic [STEP_W-1:0] S_EMIT     = 4'd5;
  localparam logic [STEP_W-1:0] S_LISTEND  = 4'd6;
  localparam logic [STEP_W-1:0] S_FULL     = 4'd7;
  localparam logic [STEP_W-1:0] S_MISALIGN = 4'd8;

  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_ACCEPT,
    C_SIZE_ZERO,
    C_NOT_VALID,
    C_FULL,
    C_NO_CODE,
    C_MORE
  } cond_e;

  typedef struct packed {
    logic              accept;
    logic              pick;
    logic              emit;
    logic [1:0]        kind;
    cond_e             cond;
    logic [STEP_W-1:0] target;
    logic [STEP_W-1:0] nxt;
  } uword_t;

  typedef struct packed {
    logic       load;
    logic       pick;
    logic       emit;
    logic [1:0] kind;
  } ctrl_t;

  typedef struct packed {
    logic size_zero;
    logic region_valid;
    logic full;
    logic no_code;
    logic more;
    logic can_emit;
  } dp_stat_t;

  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{accept: 1'b0, pick: 1'b0, emit: 1'b0, kind: ST_ENTRY,
          cond: C_NEVER, target: S_WAIT, nxt: S_WAIT};
    case (step)
      S_WAIT: begin
        w.accept = 1'b1;
        w.cond   = C_NO_ACCEPT;
        w.target = S_WAIT;
        w.nxt    = S_ENDCHK;
      end
      S_ENDCHK: begin
        w.cond   = C_SIZE_ZERO;
        w.target = S_LISTEND;
        w.nxt    = S_VALCHK;
      end
      S_VALCHK: begin
        w.cond   = C_NOT_VALID;
        w.target = S_WAIT;
        w.nxt    = S_FULLCHK;
      end
      S_FULLCHK: begin
        w.pick   = 1'b1;
        w.cond   = C_FULL;
        w.target = S_FULL;
        w.nxt    = S_CODECHK;
      end
      S_CODECHK: begin
        w.cond   = C_NO_CODE;
        w.target = S_MISALIGN;
        w.nxt    = S_EMIT;
      end
      S_EMIT: begin
        w.emit   = 1'b1;
        w.kind   = ST_ENTRY;
        w.cond   = C_MORE;
        w.target = S_FULLCHK;
        w.nxt    = S_WAIT;
      end
      S_LISTEND: begin
        w.emit = 1'b1;
        w.kind = ST_END;
      end
      S_FULL: begin
        w.emit = 1'b1;
        w.kind = ST_FULL;
      end
      S_MISALIGN: begin
        w.emit = 1'b1;
        w.kind = ST_MISALIGN;
      end
      default: begin
        w.nxt = S_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/region_to_tlb_entry_splitter_unit.sv */
// List end: wait, end check and list end emit steps; an entry passes the valid check,
// the full check with page select, the code check and the emit step. Further entries of a
// region repeat the last three; the input waits until the region's last result is emitted.
// Output register stalls the sequencer only while a result is not taken.
// Reset (rst_ni low, async): sequencer to wait step, entry count zero,
// entry_limit 16, coherent_mode 0, no result pending.
module region_to_tlb_entry_splitter_unit import rtes_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PHYS_W-1:0]     phys_addr_i,
  input  logic [VIRT_W-1:0]     virt_addr_i,
  input  logic [SIZE_W-1:0]     region_size_i,
  input  logic                  region_valid_i,
  input  logic                  guarded_i,
  input  logic                  cacheable_i,
  input  logic                  readable_i,
  input  logic                  writable_i,
  input  logic                  executable_i,
  input  logic                  temporary_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [IDX_W-1:0]      entry_index_o,
  output logic [19:0]           virt_page_o,
  output logic [23:0]           real_page_o,
  output logic [CODE_W-1:0]     size_code_o,
  output logic                  guarded_bit_o,
  output logic                  uncached_bit_o,
  output logic                  coherent_bit_o,
  output logic [2:0]            permissions_o,
  output logic                  temporary_bit_o,
  output logic [1:0]            status_o,
  output logic                  last_o
);

  ctrl_t    ctrl;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  rtes_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  rtes_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .phys_addr_i     (phys_addr_i),
    .virt_addr_i     (virt_addr_i),
    .region_size_i   (region_size_i),
    .region_valid_i  (region_valid_i),
    .guarded_i       (guarded_i),
    .cacheable_i     (cacheable_i),
    .readable_i      (readable_i),
    .writable_i      (writable_i),
    .executable_i    (executable_i),
    .temporary_i     (temporary_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .entry_index_o   (entry_index_o),
    .virt_page_o     (virt_page_o),
    .real_page_o     (real_page_o),
    .size_code_o     (size_code_o),
    .guarded_bit_o   (guarded_bit_o),
    .uncached_bit_o  (uncached_bit_o),
    .coherent_bit_o  (coherent_bit_o),
    .permissions_o   (permissions_o),
    .temporary_bit_o (temporary_bit_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

endmodule

/* rtl/rtes_sequencer.sv */
module rtes_sequencer import rtes_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output ctrl_t    ctrl_o
);

  logic [STEP_W-1:0] upc_q, upc_d;
  uword_t            w;
  logic              taken;
  logic              stall;

  assign w = ucode_rom(upc_q);

  always_comb begin
    case (w.cond)
      C_NEVER:     taken = 1'b0;
      C_NO_ACCEPT: taken = !in_valid_i;
      C_SIZE_ZERO: taken = stat_i.size_zero;
      C_NOT_VALID: taken = !stat_i.region_valid;
      C_FULL:      taken = stat_i.full;
      C_NO_CODE:   taken = stat_i.no_code;
      C_MORE:      taken = stat_i.more;
      default:     taken = 1'b0;
    endcase
  end

  assign stall = w.emit && !stat_i.can_emit;

  always_comb begin
    if (stall) begin
      upc_d = upc_q;
    end else if (taken) begin
      upc_d = w.target;
    end else begin
      upc_d = w.nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_WAIT;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign in_ready_o  = w.accept;
  assign ctrl_o.load = w.accept && in_valid_i;
  assign ctrl_o.pick = w.pick;
  assign ctrl_o.emit = w.emit && stat_i.can_emit;
  assign ctrl_o.kind = w.kind;

endmodule

/* rtl/rtes_page_sel.sv */
module rtes_page_sel import rtes_pkg::*; (
  input  logic [PHYS_W-1:0] phys_i,
  input  logic [SIZE_W-1:0] remain_i,
  output logic [CODE_W-1:0] code_o,
  output logic [SIZE_W-1:0] page_o
);

  // highest fitting code wins
  always_comb begin
    code_o = '0;
    page_o = '0;
    for (int c = 1; c <= CODE_MAX; c++) begin
      if ((remain_i >= (SIZE_W'(1) << (10 + 2 * c))) &&
          ((phys_i & ((PHYS_W'(1) << (10 + 2 * c)) - PHYS_W'(1))) == '0)) begin
        code_o = CODE_W'(c);
        page_o = SIZE_W'(1) << (10 + 2 * c);
      end
    end
  end

endmodule

/* rtl/rtes_datapath.sv */
module rtes_datapath import rtes_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_t                 ctrl_i,
  output dp_stat_t              stat_o,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [PHYS_W-1:0]     phys_addr_i,
  input  logic [VIRT_W-1:0]     virt_addr_i,
  input  logic [SIZE_W-1:0]     region_size_i,
  input  logic                  region_valid_i,
  input  logic                  guarded_i,
  input  logic                  cacheable_i,
  input  logic                  readable_i,
  input  logic                  writable_i,
  input  logic                  executable_i,
  input  logic                  temporary_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [IDX_W-1:0]      entry_index_o,
  output logic [19:0]           virt_page_o,
  output logic [23:0]           real_page_o,
  output logic [CODE_W-1:0]     size_code_o,
  output logic                  guarded_bit_o,
  output logic                  uncached_bit_o,
  output logic                  coherent_bit_o,
  output logic [2:0]            permissions_o,
  output logic                  temporary_bit_o,
  output logic [1:0]            status_o,
  output logic                  last_o
);

  localparam logic [IDX_W-1:0] MaxLimit = IDX_W'(MAX_ENTRIES);
  localparam logic [IDX_W-1:0] LastN    = IDX_W'(MAX_RESULTS - 1);

  logic [IDX_W-1:0]  limit_q;
  logic              coh_mode_q;
  logic [IDX_W-1:0]  count_q;
  logic [IDX_W-1:0]  n_q;
  logic [PHYS_W-1:0] phys_q;
  logic [VIRT_W-1:0] virt_q;
  logic [SIZE_W-1:0] remain_q;
  logic              valid_q, guard_q, cache_q, temp_q;
  logic [2:0]        perm_q;
  logic [CODE_W-1:0] code_q, code_sel;
  logic [SIZE_W-1:0] page_q, page_sel;
  logic [IDX_W-1:0]  eff_limit;
  logic              more;
  logic              out_valid_q;

  rtes_page_sel u_page_sel (
    .phys_i   (phys_q),
    .remain_i (remain_q),
    .code_o   (code_sel),
    .page_o   (page_sel)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= ENTRY_LIMIT_RST;
      coh_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_ENTRY_LIMIT) begin
        limit_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_COHERENT_MODE) begin
        coh_mode_q <= cfg_data_i[0];
      end
    end
  end

  assign eff_limit = (limit_q > MaxLimit) ? MaxLimit : limit_q;
  assign more      = (remain_q != page_q) && (n_q < LastN);

  assign stat_o.size_zero    = (remain_q == '0);
  assign stat_o.region_valid = valid_q;
  assign stat_o.full         = (count_q >= eff_limit);
  assign stat_o.no_code      = (code_q == '0);
  assign stat_o.more         = more;
  assign stat_o.can_emit     = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      phys_q   <= phys_addr_i;
      virt_q   <= virt_addr_i;
      remain_q <= region_size_i;
      valid_q  <= region_valid_i;
      guard_q  <= guarded_i;
      cache_q  <= cacheable_i;
      perm_q   <= {executable_i, writable_i, readable_i};
      temp_q   <= temporary_i;
    end else if (ctrl_i.emit && ctrl_i.kind == ST_ENTRY) begin
      remain_q <= remain_q - page_q;
      phys_q   <= phys_q + {{(PHYS_W-SIZE_W){1'b0}}, page_q};
      virt_q   <= virt_q + page_q;
    end
    if (ctrl_i.pick) begin
      code_q <= code_sel;
      page_q <= page_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      n_q     <= '0;
    end else begin
      if (ctrl_i.load) begin
        n_q <= '0;
      end else if (ctrl_i.emit && ctrl_i.kind == ST_ENTRY) begin
        n_q <= n_q + IDX_W'(1);
      end
      if (ctrl_i.emit && ctrl_i.kind == ST_ENTRY) begin
        count_q <= count_q + IDX_W'(1);
      end else if (ctrl_i.emit && ctrl_i.kind == ST_END) begin
        count_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      entry_index_o <= count_q;
      status_o      <= ctrl_i.kind;
      if (ctrl_i.kind == ST_ENTRY) begin
        virt_page_o     <= virt_q[VIRT_W-1:PAGE_SHIFT];
        real_page_o     <= phys_q[PHYS_W-1:PAGE_SHIFT];
        size_code_o     <= code_q;
        guarded_bit_o   <= guard_q;
        uncached_bit_o  <= !cache_q;
        coherent_bit_o  <= cache_q && coh_mode_q;
        permissions_o   <= perm_q;
        temporary_bit_o <= temp_q;
        last_o          <= !more;
      end else begin
        virt_page_o     <= '0;
        real_page_o     <= '0;
        size_code_o     <= '0;
        guarded_bit_o   <= 1'b0;
        uncached_bit_o  <= 1'b0;
        coherent_bit_o  <= 1'b0;
        permissions_o   <= '0;
        temporary_bit_o <= 1'b0;
        last_o          <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* bench/region_split_checker.sv */
`timescale 1ns / 100ps

module region_split_checker import rtes_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [PHYS_W-1:0]     phys_addr_i,
  input  logic [VIRT_W-1:0]     virt_addr_i,
  input  logic [SIZE_W-1:0]     region_size_i,
  input  logic                  region_valid_i,
  input  logic                  guarded_i,
  input  logic                  cacheable_i,
  input  logic                  readable_i,
  input  logic                  writable_i,
  input  logic                  executable_i,
  input  logic                  temporary_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [IDX_W-1:0]      entry_index_i,
  input  logic [19:0]           virt_page_i,
  input  logic [23:0]           real_page_i,
  input  logic [CODE_W-1:0]     size_code_i,
  input  logic                  guarded_bit_i,
  input  logic                  uncached_bit_i,
  input  logic                  coherent_bit_i,
  input  logic [2:0]            permissions_i,
  input  logic                  temporary_bit_i,
  input  logic [1:0]            status_i,
  input  logic                  last_i,
  output int unsigned           mismatch_cnt_o,
  output int unsigned           pending_o
);

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [19:0]       vpage;
    logic [23:0]       rpage;
    logic [CODE_W-1:0] code;
    logic              guard;
    logic              uncached;
    logic              coherent;
    logic [2:0]        perm;
    logic              temp;
    logic [1:0]        status;
    logic              last;
  } tlb_entry_t;

  tlb_entry_t       expected_entries[$];
  logic [IDX_W-1:0] limit_q;
  logic             coherent_q;
  logic [IDX_W-1:0] count_q;

  task automatic push_status(input logic [1:0] st);
    tlb_entry_t e;
    e        = '0;
    e.idx    = count_q;
    e.status = st;
    e.last   = 1'b1;
    expected_entries.push_back(e);
  endtask

  task automatic split_region();
    logic [PHYS_W-1:0] pa;
    logic [VIRT_W-1:0] va;
    logic [SIZE_W-1:0] left;
    logic [SIZE_W-1:0] pg;
    logic [IDX_W-1:0]  lim;
    logic [CODE_W-1:0] code;
    int                made;
    tlb_entry_t        e;
    pa   = phys_addr_i;
    va   = virt_addr_i;
    left = region_size_i;
    made = 0;
    lim  = (limit_q > MAX_ENTRIES_DEF) ? IDX_W'(MAX_ENTRIES_DEF) : limit_q;
    if (left == '0) begin
      push_status(ST_END);
      count_q = '0;
      return;
    end
    if (!region_valid_i) return;
    while (left != '0) begin
      if (count_q >= lim) begin
        push_status(ST_FULL);
        return;
      end
      code = '0;
      pg   = '0;
      // largest page that fits and matches the physical alignment
      for (int c = CODE_MAX; c >= 1; c--) begin
        if (code == '0 && left >= (32'd1 << (10 + 2 * c)) &&
            (pa & ((36'd1 << (10 + 2 * c)) - 36'd1)) == '0) begin
          code = CODE_W'(c);
          pg   = 32'd1 << (10 + 2 * c);
        end
      end
      if (code == '0) begin
        push_status(ST_MISALIGN);
        return;
      end
      e          = '0;
      e.idx      = count_q;
      e.vpage    = va[31:PAGE_SHIFT];
      e.rpage    = pa[35:PAGE_SHIFT];
      e.code     = code;
      e.guard    = guarded_i;
      e.uncached = !cacheable_i;
      e.coherent = cacheable_i & coherent_q;
      e.perm     = {executable_i, writable_i, readable_i};
      e.temp     = temporary_i;
      e.status   = ST_ENTRY;
      expected_entries.push_back(e);
      made++;
      count_q = count_q + 1'b1;
      left    = left - pg;
      pa      = pa + PHYS_W'(pg);
      va      = va + pg;
      if (made >= MAX_RESULTS) break;
    end
    if (made > 0) begin
      e      = expected_entries.pop_back();
      e.last = 1'b1;
      expected_entries.push_back(e);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (seen !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      mismatch_cnt_o++;
    end
  endtask

  task automatic check_entry();
    tlb_entry_t e;
    if (expected_entries.size() == 0) begin
      $error("unexpected result: entry_index %0d status %0d", entry_index_i, status_i);
      mismatch_cnt_o++;
      return;
    end
    e = expected_entries.pop_front();
    check_field("entry_index", e.idx, entry_index_i);
    check_field("virt_page", e.vpage, virt_page_i);
    check_field("real_page", e.rpage, real_page_i);
    check_field("size_code", e.code, size_code_i);
    check_field("guarded_bit", e.guard, guarded_bit_i);
    check_field("uncached_bit", e.uncached, uncached_bit_i);
    check_field("coherent_bit", e.coherent, coherent_bit_i);
    check_field("permissions", e.perm, permissions_i);
    check_field("temporary_bit", e.temp, temporary_bit_i);
    check_field("status", e.status, status_i);
    check_field("last", e.last, last_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_entries.delete();
      limit_q        = ENTRY_LIMIT_RST;
      coherent_q     = 1'b0;
      count_q        = '0;
      mismatch_cnt_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_entry();
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_ENTRY_LIMIT) limit_q = cfg_data_i;
        else if (cfg_index_i == CFG_COHERENT_MODE) coherent_q = cfg_data_i[0];
      end
      if (in_valid_i && in_ready_i) split_region();
    end
    pending_o <= expected_entries.size();
  end

endmodule

/* bench/tb_region_to_tlb_entry_splitter_unit.sv */
`timescale 1ns / 100ps

module tb_region_to_tlb_entry_splitter_unit;
  import rtes_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 420;
  localparam int PHASE_LEN    = 160;
  localparam int DRAIN_GAP    = 20;
  localparam int HOLD_AT      = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 1000000;

  // attribute vector: {temporary, executable, writable, readable, cacheable, guarded}
  localparam logic [5:0] ATTR_ALL = 6'h3F;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [PHYS_W-1:0]     phys_addr_i;
  logic [VIRT_W-1:0]     virt_addr_i;
  logic [SIZE_W-1:0]     region_size_i;
  logic                  region_valid_i;
  logic                  guarded_i;
  logic                  cacheable_i;
  logic                  readable_i;
  logic                  writable_i;
  logic                  executable_i;
  logic                  temporary_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [IDX_W-1:0]      entry_index_o;
  logic [19:0]           virt_page_o;
  logic [23:0]           real_page_o;
  logic [CODE_W-1:0]     size_code_o;
  logic                  guarded_bit_o;
  logic                  uncached_bit_o;
  logic                  coherent_bit_o;
  logic [2:0]            permissions_o;
  logic                  temporary_bit_o;
  logic [1:0]            status_o;
  logic                  last_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned sent_cnt;
  int unsigned cycle_cnt;
  int          hold_left;
  bit          hold_done;

  region_to_tlb_entry_splitter_unit uut (.*);

  region_split_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .phys_addr_i    (phys_addr_i),
    .virt_addr_i    (virt_addr_i),
    .region_size_i  (region_size_i),
    .region_valid_i (region_valid_i),
    .guarded_i      (guarded_i),
    .cacheable_i    (cacheable_i),
    .readable_i     (readable_i),
    .writable_i     (writable_i),
    .executable_i   (executable_i),
    .temporary_i    (temporary_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .entry_index_i  (entry_index_o),
    .virt_page_i    (virt_page_o),
    .real_page_i    (real_page_o),
    .size_code_i    (size_code_o),
    .guarded_bit_i  (guarded_bit_o),
    .uncached_bit_i (uncached_bit_o),
    .coherent_bit_i (coherent_bit_o),
    .permissions_i  (permissions_o),
    .temporary_bit_i(temporary_bit_o),
    .status_i       (status_o),
    .last_i         (last_o),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic int idle_pct(input bit for_sender);
    if (sent_cnt < PHASE_LEN) return for_sender ? 37 : 48;
    if (sent_cnt < 2 * PHASE_LEN) return for_sender ? 48 : 37;
    return 0;
  endfunction

  task automatic put_region(input logic [PHYS_W-1:0] pa, input logic [VIRT_W-1:0] va,
                            input logic [SIZE_W-1:0] sz, input logic vld,
                            input logic [5:0] attr);
    while (idle_pct(1'b1) != 0 && $urandom_range(99) < idle_pct(1'b1)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    phys_addr_i    <= pa;
    virt_addr_i    <= va;
    region_size_i  <= sz;
    region_valid_i <= vld;
    guarded_i      <= attr[0];
    cacheable_i    <= attr[1];
    readable_i     <= attr[2];
    writable_i     <= attr[3];
    executable_i   <= attr[4];
    temporary_i    <= attr[5];
    do @(posedge clk_i); while (!in_ready_o);
    sent_cnt++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] limit,
                              input logic [CFG_DATA_W-1:0] coh);
    write_reg(CFG_ENTRY_LIMIT, limit);
    write_reg(CFG_COHERENT_MODE, coh);
    cfg_valid_i <= 1'b0;
  endtask

  // wait out every expected result plus the tail of any skipped item
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  always begin
    out_ready_i <= 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && sent_cnt >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= idle_pct(1'b0));
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned       counted;
    int                nregions;
    logic [PHYS_W-1:0] pa;
    logic [VIRT_W-1:0] va;
    logic [SIZE_W-1:0] sz;
    logic [IDX_W-1:0]  lim;
    logic              vld;

    rst_ni         <= 1'b0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= '0;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    phys_addr_i    <= '0;
    virt_addr_i    <= '0;
    region_size_i  <= '0;
    region_valid_i <= 1'b0;
    guarded_i      <= 1'b0;
    cacheable_i    <= 1'b0;
    readable_i     <= 1'b0;
    writable_i     <= 1'b0;
    executable_i   <= 1'b0;
    temporary_i    <= 1'b0;
    sent_cnt = 0;
    counted  = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    program_regs(7'd64, 7'd1);
    put_region(36'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, ATTR_ALL);  // every page size, short tail
    put_region(36'hF_FFFF_F000, 32'hFFFF_F000, 32'h2000, 1'b1, 6'h15);  // address wrap
    put_region(36'h0_4000_0123, 32'h1234_5000, 32'h1_0000, 1'b1, ATTR_ALL);
    put_region(36'h0_0010_0000, 32'h0010_0000, 32'h0000_0FFF, 1'b1, 6'h00);
    put_region(36'h0_0020_0000, 32'h0020_0000, 32'h1000, 1'b0, ATTR_ALL);  // skipped
    put_region(36'h8_0000_0000, 32'h8000_0000, 32'h4000, 1'b1, 6'h01);
    put_region(36'h0_0030_0000, 32'h0030_0000, 32'h5000, 1'b1, 6'h06);
    put_region(36'h0_0040_0000, 32'h0040_0000, 32'h1000, 1'b1, 6'h0A);
    put_region(36'h0_0050_0000, 32'h0050_0000, 32'h1000, 1'b1, 6'h12);
    put_region(36'h0_0060_0000, 32'h0060_0000, 32'h1000, 1'b1, 6'h20);
    put_region(36'h0, 32'h0, 32'h0, 1'b1, ATTR_ALL);  // list end
    drain();
    program_regs(7'd1, 7'd0);
    put_region(36'h0_0000_3000, 32'h0000_3000, 32'h3000, 1'b1, ATTR_ALL);  // then full
    put_region(36'h0, 32'h0, 32'h0, 1'b0, 6'h00);
    drain();
    program_regs(7'd0, 7'd1);
    put_region(36'h0_0001_0000, 32'h0001_0000, 32'h1_0000, 1'b1, ATTR_ALL);  // always full
    put_region(36'h0, 32'h0, 32'h0, 1'b0, ATTR_ALL);
    drain();
    write_reg(CFG_UNUSED, 7'h55);
    program_regs(7'd127, 7'h7E);
    put_region(36'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, 6'h1D);
    put_region(36'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, 6'h1F);  // adds 30 more entries, still under the limit
    put_region(36'hF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1, ATTR_ALL);

    // random lists of regions, each closed by a list end
    while (counted < RANDOM_ITEMS) begin
      drain();
      case ($urandom_range(7))
        0: lim = 7'd1;
        1: lim = 7'd64;
        2: lim = 7'd127;
        3: lim = 7'd0;
        4: lim = 7'd16;
        default: lim = 7'($urandom_range(40, 2));
      endcase
      program_regs(lim, 7'($urandom_range(127)));
      repeat ($urandom_range(8, 3)) begin
        nregions = $urandom_range(6, 1);
        for (int k = 0; k < nregions; k++) begin
          pa = {4'($urandom), 32'($urandom)};
          va = $urandom;
          if ($urandom_range(9) != 0) pa = pa & ~((36'd1 << $urandom_range(30, 12)) - 36'd1);
          case ($urandom_range(9))
            0, 1, 2, 3: sz = 32'($urandom_range(48, 1)) << 12;
            4, 5: sz = $urandom;
            6, 7: sz = (32'($urandom_range(48, 1)) << 12) | 32'($urandom_range(4095, 1));
            8: sz = 32'd1 << $urandom_range(31, 12);
            default: sz = 32'($urandom_range(4095, 1));
          endcase
          vld = ($urandom_range(9) != 0);
          put_region(pa, va, sz, vld, 6'($urandom));
          if (vld) counted++;
        end
        put_region({4'($urandom), 32'($urandom)}, $urandom, 32'h0, 1'($urandom),
                   6'($urandom));
        counted++;
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/rtes_pkg.sv
rtl/rtes_sequencer.sv
rtl/rtes_page_sel.sv
rtl/rtes_datapath.sv
rtl/region_to_tlb_entry_splitter_unit.sv
bench/region_split_checker.sv
bench/tb_region_to_tlb_entry_splitter_unit.sv
